// ===== rtl/pls_pkg.sv =====
`timescale 1ns / 1ps
// pls_pkg: shared constants and types for the positional list store.
// Used by the channel interfaces, the control decode, the cells and the top level.
package pls_pkg;

   // Payload widths that the channel definitions fix.
   localparam int ACTION_W = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 8;
   localparam int STATUS_W = 2;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_INS_BACK  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_INS_POS   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_DEL_FRONT = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_DEL_BACK  = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_DEL_POS   = 3'd5;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

   // Shift command broadcast to every cell for one transfer.
   typedef struct packed {
      logic ins;   // open a gap at the index and load the new value
      logic del;   // close the gap at the index
   } cell_cmd_type;

endpackage

// ===== rtl/pls_if.sv =====
`timescale 1ns / 1ps
// pls_req_if / pls_rsp_if: valid/ready channels of the positional list store.
// Depends on pls_pkg for the payload widths.
interface pls_req_if;
   logic                           valid;
   logic                           ready;
   logic [pls_pkg::ACTION_W-1:0]   action;
   logic signed [pls_pkg::VALUE_W-1:0] value;
   logic [pls_pkg::POS_W-1:0]      position;

   modport source (output valid, action, value, position, input ready);
   modport sink   (input valid, action, value, position, output ready);
endinterface

interface pls_rsp_if #(parameter int CNT_W = 5);
   logic                           valid;
   logic                           ready;
   logic [pls_pkg::STATUS_W-1:0]   status;
   logic [CNT_W-1:0]               count;

   modport source (output valid, status, count, input ready);
   modport sink   (input valid, status, count, output ready);
endinterface

// ===== rtl/pls_ctrl.sv =====
`timescale 1ns / 1ps
// pls_ctrl: decodes one list command against the element count into status,
// next count, the cell shift command and the cell index. Depends on pls_pkg.
module pls_ctrl #(
   parameter int CAPACITY = 16,
   parameter int CNT_W    = 5,
   parameter int IDX_W    = 4
) (
   input  logic [pls_pkg::ACTION_W-1:0] action,
   input  logic [pls_pkg::POS_W-1:0]    position,
   input  logic [CNT_W-1:0]             count,
   output logic [pls_pkg::STATUS_W-1:0] status,
   output logic [CNT_W-1:0]             count_next,
   output pls_pkg::cell_cmd_type        cmd,
   output logic [IDX_W-1:0]             idx
);
   import pls_pkg::*;

   // Common compare width wide enough for both position and count + 1.
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

   logic [CMP_W-1:0] pos_w;
   logic [CMP_W-1:0] cnt_w;
   logic             full;
   logic             empty;

   assign pos_w = CMP_W'(position);
   assign cnt_w = CMP_W'(count);
   assign full  = (cnt_w >= CAP_C);
   assign empty = (count == '0);

   always_comb begin
      status     = ST_DONE;
      cmd.ins    = 1'b0;
      cmd.del    = 1'b0;
      idx        = '0;
      case (action)
         ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS: begin
            if (full) begin
               status = ST_FULL;
            end else if (action == ACT_INS_FRONT) begin
               cmd.ins = 1'b1;
            end else if (action == ACT_INS_BACK) begin
               cmd.ins = 1'b1;
               idx     = IDX_W'(cnt_w);
            end else if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) begin
               status = ST_INVALID;
            end else begin
               cmd.ins = 1'b1;
               idx     = IDX_W'(pos_w - CMP_W'(1));
            end
         end
         ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_POS: begin
            if (empty) begin
               status = ST_EMPTY;
            end else if (action == ACT_DEL_FRONT) begin
               cmd.del = 1'b1;
            end else if (action == ACT_DEL_BACK) begin
               cmd.del = 1'b1;
               idx     = IDX_W'(cnt_w - CMP_W'(1));
            end else if (pos_w == '0 || pos_w > cnt_w) begin
               status = ST_INVALID;
            end else begin
               cmd.del = 1'b1;
               idx     = IDX_W'(pos_w - CMP_W'(1));
            end
         end
         default: begin
            status = ST_INVALID;
         end
      endcase
   end

   // Count moves by one on a completed insert or delete.
   always_comb begin
      if (cmd.ins) begin
         count_next = count + CNT_W'(1);
      end else if (cmd.del) begin
         count_next = count - CNT_W'(1);
      end else begin
         count_next = count;
      end
   end

endmodule

// ===== rtl/pls_cell.sv =====
`timescale 1ns / 1ps
// pls_cell: one list element. Holds, loads the new value, or takes its
// left or right neighbor on the broadcast shift command. Depends on pls_pkg.
module pls_cell #(
   parameter int IDX_W    = 4,
   parameter int CELL_POS = 0
) (
   input  logic                            clock,
   input  logic                            shift_en,
   input  pls_pkg::cell_cmd_type           cmd,
   input  logic [IDX_W-1:0]                idx,
   input  logic [pls_pkg::VALUE_W-1:0]     value_in,
   input  logic [pls_pkg::VALUE_W-1:0]     left_data,
   input  logic [pls_pkg::VALUE_W-1:0]     right_data,
   output logic [pls_pkg::VALUE_W-1:0]     data_out
);
   import pls_pkg::*;

   localparam logic [IDX_W-1:0] POS_C = IDX_W'(CELL_POS);

   logic [VALUE_W-1:0] data_ff;
   logic [VALUE_W-1:0] data_in;

   // Insert: cells past the gap take the left neighbor, the gap takes the value.
   // Delete: cells from the gap onward take the right neighbor.
   always_comb begin
      data_in = data_ff;
      if (cmd.ins && POS_C > idx) begin
         data_in = left_data;
      end else if (cmd.ins && POS_C == idx) begin
         data_in = value_in;
      end else if (cmd.del && POS_C >= idx) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule

// ===== rtl/positional_list_store.sv =====
`timescale 1ns / 1ps
// positional_list_store: ordered list of signed 32-bit values in a row of
// cells with positional insert/delete. Depends on pls_pkg, pls_if, pls_ctrl, pls_cell.
//
//   channel   dir  fields                      transfer when
//   req_chan  in   action, value, position     valid && ready
//   rsp_chan  out  status, count               valid && ready
//
// One command per cycle while rsp_chan is not stalled: the count compare and cell shift
// finish in the transfer cycle; the result sits in an output register the cycle after.
// req_chan.ready is high while the result register is empty or being drained.
// Synchronous reset empties the list; element storage is not cleared.
// A stalled response holds the request side off; no command is lost.
module positional_list_store #(
   parameter int CAPACITY = 16
) (
   input  logic       clock,
   input  logic       reset,
   pls_req_if.sink    req_chan,
   pls_rsp_if.source  rsp_chan
);
   import pls_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   logic                  req_xfer;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [STATUS_W-1:0]   status_ff;
   logic [STATUS_W-1:0]   status_dec;
   cell_cmd_type          cmd_dec;
   cell_cmd_type          cmd;
   logic [IDX_W-1:0]      idx;
   logic [VALUE_W-1:0]    cell_data [CAPACITY];

   // Handshake: take a command whenever the result register is free.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   pls_ctrl #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W),
      .IDX_W    (IDX_W)
   ) u_ctrl (
      .action     (req_chan.action),
      .position   (req_chan.position),
      .count      (count_ff),
      .status     (status_dec),
      .count_next (count_in),
      .cmd        (cmd_dec),
      .idx        (idx)
   );

   // Only shift on a transfer.
   assign cmd.ins = cmd_dec.ins && req_xfer;
   assign cmd.del = cmd_dec.del && req_xfer;

   // Row of cells, each wired to its neighbors.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_W-1:0] left_d;
      logic [VALUE_W-1:0] right_d;
      if (i == 0) begin : g_first
         assign left_d = req_chan.value;
      end else begin : g_mid
         assign left_d = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_d = cell_data[i];
      end else begin : g_body
         assign right_d = cell_data[i+1];
      end
      pls_cell #(
         .IDX_W    (IDX_W),
         .CELL_POS (i)
      ) u_cell (
         .clock      (clock),
         .shift_en   (req_xfer),
         .cmd        (cmd),
         .idx        (idx),
         .value_in   (req_chan.value),
         .left_data  (left_d),
         .right_data (right_d),
         .data_out   (cell_data[i])
      );
   end

   // Count and response register.
   assign rsp_valid_in = req_xfer || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         status_ff <= status_dec;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = status_ff;
   assign rsp_chan.count  = count_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_ins_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the count");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_FULL |-> count_ff == CNT_W'(CAPACITY))
      else $error("full status with room left");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_EMPTY |-> count_ff == '0)
      else $error("empty status with elements held");

endmodule
